@@ rtl/iarp_pkg.sv @@
// Package for the IMU attitude / rep counter / pump PID block.
// Shared widths, register codes, CORDIC angle table and fixed constants; no dependencies.
`default_nettype none
package iarp_pkg;
	localparam int AngW = 18;
	localparam int YawW = 17;
	localparam int CfgW = 17;
	localparam int ZW = 28;
	localparam int CW = 36;
	localparam logic signed [AngW-1:0] ANG_MAX = 18'sd92160;
	localparam logic signed [YawW+1:0] YAW_HALF = 19'sd46080;

	typedef enum logic [2:0] {
		REG_TARGET = 3'd0,
		REG_GAIN_P = 3'd1,
		REG_GAIN_I = 3'd2,
		REG_GAIN_D = 3'd3,
		REG_CYCLES = 3'd4,
		REG_RAISE  = 3'd5,
		REG_LOWER  = 3'd6
	} reg_idx_t;

	function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		begin
			case (i)
				5'd0: r = 28'sd2949120;
				5'd1: r = 28'sd1740967;
				5'd2: r = 28'sd919879;
				5'd3: r = 28'sd466945;
				5'd4: r = 28'sd234379;
				5'd5: r = 28'sd117304;
				5'd6: r = 28'sd58666;
				5'd7: r = 28'sd29335;
				5'd8: r = 28'sd14668;
				5'd9: r = 28'sd7334;
				5'd10: r = 28'sd3667;
				5'd11: r = 28'sd1833;
				5'd12: r = 28'sd917;
				5'd13: r = 28'sd458;
				5'd14: r = 28'sd229;
				5'd15: r = 28'sd115;
				5'd16: r = 28'sd57;
				5'd17: r = 28'sd29;
				5'd18: r = 28'sd14;
				5'd19: r = 28'sd7;
				5'd20: r = 28'sd4;
				5'd21: r = 28'sd2;
				5'd22: r = 28'sd1;
				default: r = '0;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

@@ rtl/imu_attitude_rep_pid_pump.sv @@
// Top level of the IMU attitude filter with rep counter and pump PID.
// Uses iarp_pkg for widths, register codes and the CORDIC angle table.
//
// One sample word is taken, then processed by a sequencer: gyro deltas and
// blends go through a shared bit-serial shift-subtract divider (one quotient
// bit per cycle), the accelerometer magnitude through a two-bit-per-cycle
// square root, both atan2 evaluations through one CORDIC that does one
// vectoring step per cycle, and the PID products through a shift-add
// multiplier that retires one multiplier bit per cycle. A zero accelerometer
// vector skips the CORDIC steps of that angle. The next sample can be taken
// in the cycle after the result word is loaded; the serial divides and
// multiplies take most of the time per sample. The result word waits in an
// output register; the next sample is accepted as soon as the sequencer is
// idle, even while that word stalls.
`default_nettype none
module imu_attitude_rep_pid_pump #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire signed [15:0] acc_x,
	input  wire signed [15:0] acc_y,
	input  wire signed [15:0] acc_z,
	input  wire signed [15:0] rate_x,
	input  wire signed [15:0] rate_y,
	input  wire signed [15:0] rate_z,
	input  wire               cfg_we,
	input  wire [2:0]         cfg_index,
	input  wire [16:0]        cfg_data,
	output logic              out_valid,
	input  wire               out_stall,
	output logic signed [17:0] roll_angle,
	output logic signed [17:0] pitch_angle,
	output logic signed [16:0] yaw_angle,
	output logic signed [17:0] smooth_roll,
	output logic [15:0]       rep_total,
	output logic [7:0]        pump_drive,
	output logic              drive_active
);
	localparam int StepW = $clog2(CORDIC_STEPS + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_GDIV, S_GDIV_RUN, S_SQRT, S_SQRT_RUN, S_CSET, S_CRUN, S_CDONE,
		S_BDIV, S_BDIV_RUN, S_UPD, S_PMUL, S_PMUL_RUN, S_PDONE, S_OUT
	} state_t;

	state_t state_q;
	logic signed [16:0] target_q, raise_q, lower_q;
	logic [15:0] gp_q, gi_q, gd_q, cyc_q;

	logic signed [17:0] roll_q, pitch_q, roll_avg_q;
	logic signed [16:0] yaw_q;
	logic armed_q;
	logic [15:0] rep_q;
	logic signed [39:0] esum_q;
	logic signed [19:0] perr_q;
	logic [7:0] drive_q;
	logic act_q;

	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic [1:0] sel_q;          // which of three gyro / two blend / two angle jobs
	logic signed [19:0] gd_res_q [3];
	logic signed [17:0] acc_ang_q [2];
	logic [23:0] mag_q;

	// serial divider: |n| / d, 32-bit dividend
	logic [31:0] dv_n_q;
	logic [15:0] dv_r_q;
	logic [5:0] dv_cnt_q;
	logic dv_neg_q;
	logic [14:0] dv_d_q;

	// square root, 2 bits per cycle
	logic [47:0] sq_v_q;
	logic [47:0] sq_rem_q;
	logic [23:0] sq_root_q;
	logic [4:0] sq_cnt_q;

	// CORDIC
	logic signed [iarp_pkg::CW-1:0] cx_q, cy_q;
	logic signed [iarp_pkg::ZW-1:0] cz_q;
	logic [StepW-1:0] ci_q;
	logic [4:0] ci5;

	// PID multiplier
	logic [15:0] mb_q;
	logic signed [41:0] ma_q;
	logic signed [63:0] macc_q;
	logic [4:0] mcnt_q;
	logic [1:0] mterm_q;
	logic signed [19:0] err_q;

	logic in_acc, out_acc, load_out;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	// result word moves into the output register once that register is free
	assign load_out = (state_q == S_OUT) && !(mterm_q == 2'd3 && act_q)
		&& (!out_valid || out_acc);

	// combinational helpers
	logic [16:0] dv_trial;
	logic [15:0] dv_rnext;
	logic [47:0] sq_tr;
	logic [47:0] sq_rw;
	logic signed [iarp_pkg::CW-1:0] c_dx, c_dy;
	logic signed [iarp_pkg::ZW-1:0] c_fin;
	logic signed [19:0] q_signed;

	assign dv_trial = {dv_r_q, dv_n_q[31]} - {2'b0, dv_d_q};
	assign dv_rnext = dv_trial[16] ? {dv_r_q[14:0], dv_n_q[31]} : dv_trial[15:0];
	assign sq_rw = {sq_rem_q[45:0], sq_v_q[47:46]};
	assign sq_tr = sq_rw - {22'b0, sq_root_q, 2'b01};
	assign ci5 = 5'(ci_q);
	assign c_dx = cy_q >>> ci_q;
	assign c_dy = cx_q >>> ci_q;
	assign c_fin = (cz_q + iarp_pkg::ZW'(128)) >>> 8;
	assign q_signed = dv_neg_q ? -$signed({1'b0, dv_n_q[18:0]}) : $signed({1'b0, dv_n_q[18:0]});

	// blend numerator 19*g + a, |value| < 2^23
	logic signed [25:0] bl_num;
	always_comb begin
		bl_num = 26'sd19 * 26'(gd_res_q[sel_q]) + 26'(acc_ang_q[sel_q[0]]);
	end

	logic signed [18:0] yaw_sum;
	logic signed [17:0] nroll;
	logic signed [18:0] avg_sum;
	logic signed [19:0] err_c;
	logic signed [40:0] esum_c;
	logic [15:0] rep_n;
	logic arm_n;
	logic signed [63:0] shifted;

	always_comb begin
		yaw_sum = 19'(yaw_q) + 19'(gd_res_q[2]);
		nroll = roll_q;
		avg_sum = 19'(roll_avg_q) + 19'(roll_q);
		err_c = -20'(roll_avg_q) - 20'(target_q);
		esum_c = 41'(esum_q) + 41'(err_c);
		rep_n = rep_q;
		arm_n = armed_q;
		if (nroll > 18'(raise_q)) begin
			arm_n = 1'b1;
		end else if (nroll < 18'(lower_q) && armed_q) begin
			arm_n = 1'b0;
			if (rep_q != 16'hFFFF) rep_n = rep_q + 16'd1;
		end
		shifted = macc_q >>> 18;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			target_q <= 17'sd5120; gp_q <= 16'd15360; gi_q <= 16'd10;
			gd_q <= 16'd5120; cyc_q <= 16'd3;
			raise_q <= -17'sd20480; lower_q <= -17'sd21760;
			roll_q <= '0; pitch_q <= '0; yaw_q <= '0; roll_avg_q <= '0;
			armed_q <= 1'b0; rep_q <= '0; esum_q <= '0; perr_q <= '0; drive_q <= '0;
			act_q <= 1'b0; mterm_q <= '0;
			out_valid <= 1'b0;
			roll_angle <= '0; pitch_angle <= '0; yaw_angle <= '0; smooth_roll <= '0;
			rep_total <= '0; pump_drive <= '0;
			drive_active <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					iarp_pkg::REG_TARGET: target_q <= $signed(cfg_data);
					iarp_pkg::REG_GAIN_P: gp_q <= cfg_data[15:0];
					iarp_pkg::REG_GAIN_I: gi_q <= cfg_data[15:0];
					iarp_pkg::REG_GAIN_D: gd_q <= cfg_data[15:0];
					iarp_pkg::REG_CYCLES: cyc_q <= cfg_data[15:0];
					iarp_pkg::REG_RAISE: raise_q <= $signed(cfg_data);
					iarp_pkg::REG_LOWER: lower_q <= $signed(cfg_data);
					default: ;
				endcase
			end
			if (load_out) out_valid <= 1'b1;
			else if (out_acc) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						ax_q <= acc_x; ay_q <= acc_y; az_q <= acc_z;
						gx_q <= rate_x; gy_q <= rate_y; gz_q <= rate_z;
						sel_q <= 2'd0;
						state_q <= S_GDIV;
					end
				end
				S_GDIV: begin
					// |rate*256| + 8187, divide by 16375
					logic signed [15:0] g;
					g = (sel_q == 2'd0) ? gx_q : (sel_q == 2'd1) ? gy_q : gz_q;
					dv_neg_q <= g[15];
					dv_n_q <= 32'((g[15] ? -25'(g) : 25'(g)) * 25'sd256) + 32'd8187;
					dv_d_q <= 15'd16375;
					dv_r_q <= '0;
					dv_cnt_q <= '0;
					state_q <= S_GDIV_RUN;
				end
				S_GDIV_RUN: begin
					dv_r_q <= dv_rnext;
					dv_n_q <= {dv_n_q[30:0], ~dv_trial[16]};
					dv_cnt_q <= dv_cnt_q + 6'd1;
					if (dv_cnt_q == 6'd31) begin
						state_q <= (sel_q == 2'd2) ? S_SQRT : S_GDIV;
						sel_q <= sel_q + 2'd1;
					end
					if (dv_cnt_q == 6'd31) gd_res_q[sel_q] <= 20'(0);
				end
				default: ;
			endcase
			// quotient capture after last shift
			if (state_q == S_GDIV && sel_q != 2'd0)
				gd_res_q[sel_q - 2'd1] <= q_signed + 20'(roll_q) * 20'(sel_q == 2'd1)
					+ 20'(pitch_q) * 20'(sel_q == 2'd2);
			if (state_q == S_SQRT) begin
				gd_res_q[2] <= q_signed;
				sq_v_q <= 48'(($signed(32'(ax_q) * 32'(ax_q)) + $signed(32'(az_q) * 32'(az_q)))) << 16;
				sq_rem_q <= '0; sq_root_q <= '0; sq_cnt_q <= '0;
				state_q <= S_SQRT_RUN;
			end
			if (state_q == S_SQRT_RUN) begin
				sq_v_q <= sq_v_q << 2;
				if (!sq_tr[47]) begin
					sq_rem_q <= sq_tr; sq_root_q <= {sq_root_q[22:0], 1'b1};
				end else begin
					sq_rem_q <= sq_rw; sq_root_q <= {sq_root_q[22:0], 1'b0};
				end
				sq_cnt_q <= sq_cnt_q + 5'd1;
				if (sq_cnt_q == 5'd23) begin
					sel_q <= 2'd0;
					state_q <= S_CSET;
				end
			end
			if (state_q == S_CSET) begin
				logic signed [iarp_pkg::CW-1:0] x0, y0;
				if (sel_q == 2'd0) begin
					mag_q <= sq_root_q;
					x0 = iarp_pkg::CW'(az_q) <<< 8; y0 = -(iarp_pkg::CW'(ax_q) <<< 8);
				end else begin
					x0 = iarp_pkg::CW'({1'b0, mag_q}); y0 = iarp_pkg::CW'(ay_q) <<< 8;
				end
				if (x0 < 0) begin
					cx_q <= -x0; cy_q <= -y0;
					cz_q <= (y0 >= 0) ? iarp_pkg::ZW'(180 * 65536) : -iarp_pkg::ZW'(180 * 65536);
				end else begin
					cx_q <= x0; cy_q <= y0;
					// zero vector: preset so the rounding gives angle zero
					cz_q <= (x0 == 0 && y0 == 0) ? -iarp_pkg::ZW'(128) : '0;
				end
				ci_q <= '0;
				state_q <= (x0 == 0 && y0 == 0) ? S_CDONE : S_CRUN;
			end
			if (state_q == S_CRUN) begin
				if (cy_q > 0) begin
					cx_q <= cx_q + c_dx; cy_q <= cy_q - c_dy;
					cz_q <= cz_q + iarp_pkg::atan_entry(ci5);
				end else begin
					cx_q <= cx_q - c_dx; cy_q <= cy_q + c_dy;
					cz_q <= cz_q - iarp_pkg::atan_entry(ci5);
				end
				ci_q <= ci_q + StepW'(1);
				if (ci_q == StepW'(CORDIC_STEPS - 1)) state_q <= S_CDONE;
			end
			if (state_q == S_CDONE) begin
				acc_ang_q[sel_q[0]] <= 18'(c_fin);
				sel_q <= (sel_q == 2'd0) ? 2'd1 : 2'd0;
				state_q <= (sel_q == 2'd0) ? S_CSET : S_BDIV;
			end
			if (state_q == S_BDIV) begin
				dv_neg_q <= bl_num[25];
				dv_n_q <= 32'(bl_num[25] ? -bl_num : bl_num) + 32'd10;
				dv_d_q <= 15'd20;
				dv_r_q <= '0; dv_cnt_q <= '0;
				state_q <= S_BDIV_RUN;
			end
			if (state_q == S_BDIV_RUN) begin
				dv_r_q <= dv_rnext;
				dv_n_q <= {dv_n_q[30:0], ~dv_trial[16]};
				dv_cnt_q <= dv_cnt_q + 6'd1;
				if (dv_cnt_q == 6'd31) begin
					if (sel_q == 2'd0) begin
						sel_q <= 2'd1; state_q <= S_BDIV;
					end else state_q <= S_UPD;
				end
			end
			if ((state_q == S_BDIV && sel_q == 2'd1) || state_q == S_UPD) begin
				logic signed [19:0] v;
				v = q_signed;
				if (v > 20'(iarp_pkg::ANG_MAX)) v = 20'(iarp_pkg::ANG_MAX);
				if (v < -20'(iarp_pkg::ANG_MAX)) v = -20'(iarp_pkg::ANG_MAX);
				if (state_q == S_UPD) pitch_q <= 18'(v); else roll_q <= 18'(v);
			end
			if (state_q == S_UPD) state_q <= S_PDONE;
			if (state_q == S_PDONE) begin
				// roll_q now final
				if (yaw_sum > iarp_pkg::YAW_HALF) yaw_q <= 17'(yaw_sum - 19'sd92160);
				else if (yaw_sum < -iarp_pkg::YAW_HALF) yaw_q <= 17'(yaw_sum + 19'sd92160);
				else yaw_q <= 17'(yaw_sum);
				roll_avg_q <= 18'(avg_sum >>> 1);
				armed_q <= arm_n; rep_q <= rep_n;
				if ({16'b0, rep_n} > {16'b0, cyc_q}) begin
					state_q <= S_PMUL;
					mterm_q <= 2'd0;
					macc_q <= '0;
				end else begin
					act_q <= 1'b0;
					state_q <= S_OUT;
				end
			end
			if (state_q == S_PMUL) begin
				if (mterm_q == 2'd0) begin
					err_q <= err_c;
					if (esum_c > 41'sh7F_FFFF_FFFF) esum_q <= 40'sh7F_FFFF_FFFF;
					else if (esum_c < -41'sh80_0000_0000) esum_q <= -40'sh80_0000_0000;
					else esum_q <= 40'(esum_c);
					ma_q <= 42'(err_c); mb_q <= gp_q;
				end else if (mterm_q == 2'd1) begin
					ma_q <= 42'(esum_q); mb_q <= gi_q;
				end else begin
					ma_q <= 42'(err_q) - 42'(perr_q); mb_q <= gd_q;
				end
				mcnt_q <= '0;
				state_q <= S_PMUL_RUN;
			end
			if (state_q == S_PMUL_RUN) begin
				if (mb_q[0]) macc_q <= macc_q + (64'(ma_q) <<< mcnt_q);
				mb_q <= mb_q >> 1;
				mcnt_q <= mcnt_q + 5'd1;
				if (mcnt_q == 5'd15) begin
					if (mterm_q == 2'd2) begin
						state_q <= S_OUT;
						perr_q <= err_q;
						act_q <= 1'b1;
						mterm_q <= 2'd3;
					end else begin
						mterm_q <= mterm_q + 2'd1;
						state_q <= S_PMUL;
					end
				end
			end
			if (state_q == S_OUT) begin
				if (mterm_q == 2'd3 && act_q) begin
					if (shifted < 0) drive_q <= 8'd0;
					else if (shifted > 64'sd255) drive_q <= 8'd255;
					else drive_q <= shifted[7:0];
					mterm_q <= 2'd0;
				end else if (load_out) begin
					roll_angle <= roll_q;
					pitch_angle <= pitch_q;
					yaw_angle <= yaw_q;
					smooth_roll <= roll_avg_q;
					rep_total <= rep_q;
					pump_drive <= drive_q;
					drive_active <= act_q;
					state_q <= S_IDLE;
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ dv/imu_attitude_rep_pid_pump_tb.sv @@
// Self-checking testbench for imu_attitude_rep_pid_pump.
// Needs iarp_pkg for register codes. Queue-fed driver, monitor with a
// scoreboard against an in-bench attitude/rep/PID predictor.
`default_nettype none
module imu_attitude_rep_pid_pump_tb;
	localparam int STEPS = 16;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam longint SUM_HI = (64'sd1 <<< 39) - 1;
	localparam longint SUM_LO = -SUM_HI - 1;

	typedef struct {
		logic signed [15:0] ax, ay, az, gx, gy, gz;
	} sample_t;

	typedef struct {
		logic signed [17:0] roll, pitch, smooth;
		logic signed [16:0] yaw;
		logic [15:0] reps;
		logic [7:0] drive;
		logic active;
	} attitude_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic signed [15:0] acc_x = 0, acc_y = 0, acc_z = 0;
	logic signed [15:0] rate_x = 0, rate_y = 0, rate_z = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = iarp_pkg::REG_TARGET;
	logic [16:0] cfg_data = 0;
	logic out_stall = 0;
	wire in_stall, out_valid, drive_active;
	wire signed [17:0] roll_angle, pitch_angle, smooth_roll;
	wire signed [16:0] yaw_angle;
	wire [15:0] rep_total;
	wire [7:0] pump_drive;

	imu_attitude_rep_pid_pump u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
		.rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
		.smooth_roll(smooth_roll), .rep_total(rep_total), .pump_drive(pump_drive),
		.drive_active(drive_active)
	);

	always #5 clk = ~clk;

	sample_t pending_samples[$];
	attitude_t expected_attitude[$];
	int errors = 0;
	longint cycles = 0;
	bit calm = 0;	// phase with no idling on either side

	// predictor copy of registers and state
	longint p_target, p_raise, p_lower;
	longint p_kp, p_ki, p_kd, p_cycles;
	longint roll_e, pitch_e, yaw_e, roll_m, err_sum, err_prev;
	int armed, reps, drive;
	longint atan_lut[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
		58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0};

	function automatic longint div_near(longint n, longint d);
		if (n >= 0) return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint floor_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	function automatic longint vector_angle(longint x, longint y);
		longint base, z, dx, dy;
		base = 0;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			base = (y >= 0) ? 180 * 65536 : -180 * 65536;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += atan_lut[i];
			end else begin
				x -= dx; y += dy; z -= atan_lut[i];
			end
		end
		return (base + z + 128) >>> 8;
	endfunction

	task automatic set_defaults();
		p_target = 5120; p_kp = 15360; p_ki = 10; p_kd = 5120;
		p_cycles = 3; p_raise = -20480; p_lower = -21760;
		roll_e = 0; pitch_e = 0; yaw_e = 0; roll_m = 0;
		err_sum = 0; err_prev = 0; armed = 0; reps = 0; drive = 0;
	endtask

	task automatic predict_attitude(input sample_t s);
		longint ax, ay, az, g_roll, g_pitch, yaw, a_roll, a_pitch, e, acc;
		attitude_t r;
		ax = s.ax; ay = s.ay; az = s.az;
		g_roll = roll_e + div_near(longint'(s.gx) * 256, 16375);
		g_pitch = pitch_e + div_near(longint'(s.gy) * 256, 16375);
		yaw = yaw_e + div_near(longint'(s.gz) * 256, 16375);
		a_roll = vector_angle(az * 256, -ax * 256);
		a_pitch = vector_angle(floor_root(longint'(ax * ax + az * az) << 16), ay * 256);
		roll_e = clamp(div_near(19 * g_roll + a_roll, 20), -92160, 92160);
		pitch_e = clamp(div_near(19 * g_pitch + a_pitch, 20), -92160, 92160);
		if (yaw > 46080) yaw -= 92160;
		else if (yaw < -46080) yaw += 92160;
		yaw_e = yaw;
		roll_m = (roll_m + roll_e) >>> 1;
		if (roll_e > p_raise) begin
			armed = 1;
		end else if (roll_e < p_lower && armed != 0) begin
			armed = 0;
			if (reps < 65535) reps++;
		end
		r.active = 0;
		if (reps > p_cycles) begin
			e = -roll_m - p_target;
			err_sum = clamp(err_sum + e, SUM_LO, SUM_HI);
			acc = p_kp * e + p_ki * err_sum + p_kd * (e - err_prev);
			drive = int'(clamp(acc >>> 18, 0, 255));
			err_prev = e;
			r.active = 1;
		end
		r.roll = roll_e[17:0]; r.pitch = pitch_e[17:0]; r.yaw = yaw_e[16:0];
		r.smooth = roll_m[17:0]; r.reps = reps[15:0]; r.drive = drive[7:0];
		expected_attitude.push_back(r);
	endtask

	function automatic int draw_gap();
		if (calm) return 0;
		return $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
	endfunction

	// driver
	int in_gap = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (in_valid && !in_stall) begin
			sample_t cur;
			int g;
			cur = '{acc_x, acc_y, acc_z, rate_x, rate_y, rate_z};
			predict_attitude(cur);
			g = draw_gap();
			if (g == 0 && pending_samples.size() != 0) begin
				sample_t nx;
				nx = pending_samples.pop_front();
				acc_x <= nx.ax; acc_y <= nx.ay; acc_z <= nx.az;
				rate_x <= nx.gx; rate_y <= nx.gy; rate_z <= nx.gz;
			end else begin
				in_valid <= 0;
				in_gap <= g;
			end
		end else if (!in_valid && arst_n) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
			end else if (pending_samples.size() != 0) begin
				sample_t nx;
				nx = pending_samples.pop_front();
				acc_x <= nx.ax; acc_y <= nx.ay; acc_z <= nx.az;
				rate_x <= nx.gx; rate_y <= nx.gy; rate_z <= nx.gz;
				in_valid <= 1;
			end
		end
	end

	// monitor and scoreboard
	int out_hold = 0;
	always @(posedge clk) begin
		int h;
		h = out_hold;
		if (out_valid && !out_stall) begin
			if (expected_attitude.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				attitude_t x;
				x = expected_attitude.pop_front();
				if (roll_angle !== x.roll) begin
					$error("roll_angle exp %0d got %0d", x.roll, roll_angle); errors++;
				end
				if (pitch_angle !== x.pitch) begin
					$error("pitch_angle exp %0d got %0d", x.pitch, pitch_angle); errors++;
				end
				if (yaw_angle !== x.yaw) begin
					$error("yaw_angle exp %0d got %0d", x.yaw, yaw_angle); errors++;
				end
				if (smooth_roll !== x.smooth) begin
					$error("smooth_roll exp %0d got %0d", x.smooth, smooth_roll); errors++;
				end
				if (rep_total !== x.reps) begin
					$error("rep_total exp %0d got %0d", x.reps, rep_total); errors++;
				end
				if (pump_drive !== x.drive) begin
					$error("pump_drive exp %0d got %0d", x.drive, pump_drive); errors++;
				end
				if (drive_active !== x.active) begin
					$error("drive_active exp %0d got %0d", x.active, drive_active); errors++;
				end
			end
			h = draw_gap();
		end else if (h > 0) begin
			h--;
		end
		out_hold <= h;
		out_stall <= (h > 0);
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input longint v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v[16:0];
		case (idx)
			iarp_pkg::REG_TARGET: p_target = longint'($signed(v[16:0]));
			iarp_pkg::REG_GAIN_P: p_kp = v[15:0];
			iarp_pkg::REG_GAIN_I: p_ki = v[15:0];
			iarp_pkg::REG_GAIN_D: p_kd = v[15:0];
			iarp_pkg::REG_CYCLES: p_cycles = v[15:0];
			iarp_pkg::REG_RAISE: p_raise = longint'($signed(v[16:0]));
			iarp_pkg::REG_LOWER: p_lower = longint'($signed(v[16:0]));
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain();
		while (pending_samples.size() != 0 || in_valid || expected_attitude.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic push_sample(input int ax, ay, az, gx, gy, gz);
		sample_t s;
		s = '{ax[15:0], ay[15:0], az[15:0], gx[15:0], gy[15:0], gz[15:0]};
		pending_samples.push_back(s);
	endtask

	// mostly arm sweeps: gyro and accel pull roll the same way, so the
	// hysteresis flag toggles; the rest is raw noise
	task automatic queue_sweeps(input int n);
		int left, dir, len;
		dir = 1;
		left = 0;
		len = 0;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				push_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else begin
				if (left == 0) begin
					dir = -dir;
					left = $urandom_range(20, 90);
				end
				left--;
				push_sample(-dir * $urandom_range(8000, 32767),
					$urandom_range(0, 65535) - 32768, $urandom_range(0, 8000) - 4000,
					dir * $urandom_range(4000, 32767),
					$urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
			end
		end
	endtask

	initial begin
		set_defaults();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: zero vector, axis extremes, left half plane, repeated full-scale rates
		push_sample(0, 0, 0, 0, 0, 0);
		push_sample(32767, 32767, 32767, 32767, 32767, 32767);
		push_sample(-32768, -32768, -32768, -32768, -32768, -32768);
		push_sample(0, 0, -32768, 0, 0, 0);
		push_sample(0, 100, -20000, 0, 0, 0);
		push_sample(0, -100, -20000, 0, 0, 0);
		push_sample(1, 0, -1, 0, 0, 0);
		push_sample(-32768, 0, 0, 0, 0, 0);
		push_sample(32767, 0, 0, 0, 0, 0);
		push_sample(0, 32767, 0, 0, 0, 0);
		push_sample(0, -32768, 0, 0, 0, 0);
		push_sample(0, 0, 1, 32, -32, 31);
		for (int k = 0; k < 12; k++)
			push_sample(32767, 0, 0, -32768, 0, 32767);
		drain();

		queue_sweeps(170);
		drain();

		// extremes: an end of every register's range, ignored index too
		calm = 1;
		write_reg(iarp_pkg::REG_TARGET, 46080);
		write_reg(iarp_pkg::REG_GAIN_P, 65535);
		write_reg(iarp_pkg::REG_GAIN_I, 65535);
		write_reg(iarp_pkg::REG_GAIN_D, 65535);
		write_reg(iarp_pkg::REG_CYCLES, 0);
		write_reg(iarp_pkg::REG_RAISE, 46080);
		write_reg(iarp_pkg::REG_LOWER, -46080);
		write_reg(REG_UNUSED, 12345);
		queue_sweeps(170);
		drain();

		calm = 0;
		write_reg(iarp_pkg::REG_TARGET, -46080);
		write_reg(iarp_pkg::REG_GAIN_P, 0);
		write_reg(iarp_pkg::REG_GAIN_I, 0);
		write_reg(iarp_pkg::REG_GAIN_D, 0);
		write_reg(iarp_pkg::REG_CYCLES, 65535);
		write_reg(iarp_pkg::REG_RAISE, -46080);
		write_reg(iarp_pkg::REG_LOWER, 46080);
		queue_sweeps(100);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			write_reg(iarp_pkg::REG_TARGET, $urandom_range(0, 92160) - 46080);
			write_reg(iarp_pkg::REG_GAIN_P, $urandom_range(0, 65535));
			write_reg(iarp_pkg::REG_GAIN_I, $urandom_range(0, 400));
			write_reg(iarp_pkg::REG_GAIN_D, $urandom_range(0, 65535));
			write_reg(iarp_pkg::REG_CYCLES, $urandom_range(0, 4));
			write_reg(iarp_pkg::REG_RAISE, $urandom_range(0, 30000) - 15000);
			write_reg(iarp_pkg::REG_LOWER, $urandom_range(0, 30000) - 25000);
			queue_sweeps(140);
			drain();
		end

		if (expected_attitude.size() != 0) errors++;
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
